/* rtl/iprc_pkg.sv */
// Shared types for the interval partition room counter.
package iprc_pkg;

  typedef struct packed {
    logic [31:0] start_time;
    logic [31:0] end_time;
    logic        last;
  } in_t;

  typedef struct packed {
    logic [7:0] extra_attendees;
    logic       overflow;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH_I,
    ST_LATCH_I,
    ST_FETCH_K,
    ST_CMP_K,
    ST_NEXT_I,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic start_set;
    logic rd_i;
    logic latch_i;
    logic rd_k;
    logic cmp_k;
    logic next_i;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic i_last;
    logic k_last;
    logic out_busy;
  } stat_t;

endpackage

/* rtl/iprc_ctrl.sv */
// Sequencer for loading, the pairwise overlap scan and result hand-off.
module iprc_ctrl import iprc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  in_last_i,
  output logic  in_stall_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (in_valid_i && in_last_i) state_d = ST_FETCH_I;
      ST_FETCH_I: state_d = ST_LATCH_I;
      ST_LATCH_I: state_d = ST_FETCH_K;
      ST_FETCH_K: state_d = ST_CMP_K;
      ST_CMP_K:   state_d = stat_i.k_last ? ST_NEXT_I : ST_FETCH_K;
      ST_NEXT_I:  state_d = stat_i.i_last ? ST_FINISH : ST_FETCH_I;
      ST_FINISH:  if (!stat_i.out_busy) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o      = 1'b0;
        cmd_o.load      = in_valid_i;
        cmd_o.start_set = in_valid_i && in_last_i;
      end
      ST_FETCH_I: cmd_o.rd_i    = 1'b1;
      ST_LATCH_I: cmd_o.latch_i = 1'b1;
      ST_FETCH_K: cmd_o.rd_k    = 1'b1;
      ST_CMP_K:   cmd_o.cmp_k   = 1'b1;
      ST_NEXT_I:  cmd_o.next_i  = 1'b1;
      ST_FINISH:  cmd_o.finish  = !stat_i.out_busy;
      default: ;
    endcase
  end

endmodule

/* rtl/iprc_dp.sv */
// Activity store, scan counters, overlap counter and result register.
module iprc_dp import iprc_pkg::*; #(
  parameter int MaxActivities = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  in_t  in_data_i,
  input  cmd_t cmd_i,
  output stat_t stat_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int IW = (MaxActivities > 1) ? $clog2(MaxActivities) : 1;
  localparam int CW = $clog2(MaxActivities + 1);

  logic [63:0]   mem [MaxActivities];
  logic [63:0]   rdata_q;
  logic [IW-1:0] rd_addr;
  logic [CW-1:0] count_q, best_q, cnt_q;
  logic [IW-1:0] i_q, k_q;
  logic          drop_q, out_valid_q;
  logic [31:0]   si_q, ei_q, sk, ek;
  logic [CW-1:0] rooms;
  out_t          out_q;

  assign rd_addr = cmd_i.rd_i ? i_q : k_q;
  assign sk      = rdata_q[63:32];
  assign ek      = rdata_q[31:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (count_q < CW'(MaxActivities))) begin
      mem[count_q[IW-1:0]] <= {in_data_i.start_time, in_data_i.end_time};
    end
    if (cmd_i.rd_i || cmd_i.rd_k) begin
      rdata_q <= mem[rd_addr];
    end
    if (cmd_i.latch_i) begin
      si_q <= sk;
      ei_q <= ek;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      drop_q      <= 1'b0;
      best_q      <= '0;
      cnt_q       <= '0;
      i_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.finish) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (cmd_i.load) begin
        if (count_q < CW'(MaxActivities)) count_q <= count_q + 1'b1;
        else drop_q <= 1'b1;
      end
      if (cmd_i.start_set) begin
        best_q <= '0;
        i_q    <= '0;
      end
      if (cmd_i.latch_i) begin
        cnt_q <= '0;
        k_q   <= '0;
      end
      if (cmd_i.cmp_k) begin
        if ((ek > sk) && (sk <= si_q) && (ek > si_q)) cnt_q <= cnt_q + 1'b1;
        k_q <= k_q + 1'b1;
      end
      if (cmd_i.next_i) begin
        if ((ei_q > si_q) && (cnt_q > best_q)) best_q <= cnt_q;
        i_q <= i_q + 1'b1;
      end
      if (cmd_i.finish) begin
        count_q     <= '0;
        drop_q      <= 1'b0;
      end
    end
  end

  assign rooms = (best_q == '0) ? '0 : best_q - 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q.extra_attendees <= (rooms > CW'(255)) ? 8'd255 : 8'(rooms);
      out_q.overflow        <= drop_q;
    end
  end

  assign stat_o.i_last   = ({1'b0, i_q} == CW'(count_q - 1'b1));
  assign stat_o.k_last   = ({1'b0, k_q} == CW'(count_q - 1'b1));
  assign stat_o.out_busy = out_valid_q && out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

endmodule

/* rtl/interval_partition_room_count_top.sv */
// Loading takes one beat per cycle; from the closing beat, input stalls until the result is registered.
// The scan checks every stored activity against all of them through the single store read port.
// A new set may load while a finished result still waits to be taken.
// Reset is asynchronous and active low; it empties the set, the store contents are undefined.
// Top level of the interval partition room counter.
module interval_partition_room_count_top import iprc_pkg::*; #(
  parameter int MAX_ACTIVITIES = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  cmd_t  cmd;
  stat_t stat;

  iprc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.last),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  iprc_dp #(.MaxActivities(MAX_ACTIVITIES)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* tb/interval_partition_room_count_top_tb.sv */
// Self-checking testbench for the interval partition room counter.
module interval_partition_room_count_top_tb;
  import iprc_pkg::*;

  localparam int MAX_ACT   = 256;
  localparam int CYC_LIMIT = 6000000;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o;
  in_t  in_data_i;
  logic out_valid_o, out_stall_i;
  out_t out_data_o;

  interval_partition_room_count_top #(.MAX_ACTIVITIES(MAX_ACT)) i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  in_t          pending_beats[$];
  out_t         expected_counts[$];
  logic [31:0]  set_starts[$];
  logic [31:0]  set_ends[$];
  logic         set_dropped;
  int           errors;
  int           cycle_count;
  bit           quiet_phase;
  bit           hold_sink;
  int           hold_cycles;
  int           src_gap, sink_gap;
  bit           sink_stall_q;
  bit           in_taken;

  // Predicts the room count over the current set, and closes the set.
  function automatic out_t count_rooms();
    int   depth, best, n, a, b, k;
    out_t r;
    logic [31:0] ss[$];
    logic [31:0] es[$];
    best = 0;
    for (k = 0; k < set_starts.size(); k++) begin
      if (set_ends[k] > set_starts[k]) begin
        ss.push_back(set_starts[k]);
        es.push_back(set_ends[k]);
      end
    end
    ss.sort();
    es.sort();
    n = ss.size();
    a = 0; b = 0; depth = 0;
    while (a < n) begin
      if (b < n && es[b] <= ss[a]) begin
        if (depth > 0) depth--;
        b++;
      end else begin
        depth++;
        if (depth > best) best = depth;
        a++;
      end
    end
    if (best < 1) best = 1;
    best = best - 1;
    if (best > 255) best = 255;
    r.extra_attendees = best[7:0];
    r.overflow = set_dropped;
    set_starts.delete();
    set_ends.delete();
    set_dropped = 1'b0;
    return r;
  endfunction

  task automatic add_activity(input logic [31:0] s, input logic [31:0] e, input logic l);
    in_t b;
    b.start_time = s;
    b.end_time = e;
    b.last = l;
    pending_beats.push_back(b);
  endtask

  function automatic logic [31:0] rand_time(input int span);
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'hFFFF_FFFF - $urandom_range(0, span);
      default: return $urandom_range(0, span);
    endcase
  endfunction

  task automatic add_random_set(input int n, input int span);
    logic [31:0] s, e;
    for (int k = 0; k < n; k++) begin
      s = rand_time(span);
      if ($urandom_range(0, 9) == 0) e = rand_time(span);
      else e = s + $urandom_range(0, span);
      add_activity(s, e, k == n - 1);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Driver: predicts at the accepting edge, presents beats at the falling edge.
  always @(posedge clk_i) begin
    in_taken = rst_ni && in_valid_i && !in_stall_o;
    if (in_taken) begin
      if (set_starts.size() < MAX_ACT) begin
        set_starts.push_back(in_data_i.start_time);
        set_ends.push_back(in_data_i.end_time);
      end else begin
        set_dropped = 1'b1;
      end
      if (in_data_i.last) expected_counts.push_back(count_rooms());
      void'(pending_beats.pop_front());
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_taken) begin
    end else if (src_gap > 0) begin
      src_gap <= src_gap - 1;
      in_valid_i <= 1'b0;
    end else if (pending_beats.size() > 0) begin
      if (!quiet_phase && $urandom_range(0, 19) == 0) begin
        src_gap <= $urandom_range(0, 15);
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_beats[0];
      end
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Monitor and receiver stall.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !sink_stall_q) begin
      if (expected_counts.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data_o);
        errors++;
      end else begin
        if (out_data_o.extra_attendees !== expected_counts[0].extra_attendees) begin
          $display("%0t: extra_attendees expected %0d actual %0d", $time,
                   expected_counts[0].extra_attendees, out_data_o.extra_attendees);
          errors++;
        end
        if (out_data_o.overflow !== expected_counts[0].overflow) begin
          $display("%0t: overflow expected %0d actual %0d", $time,
                   expected_counts[0].overflow, out_data_o.overflow);
          errors++;
        end
        void'(expected_counts.pop_front());
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
      sink_stall_q <= 1'b1;
    end else if (hold_sink) begin
      hold_cycles <= 3000;
      out_stall_i <= 1'b1;
      sink_stall_q <= 1'b1;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      out_stall_i <= 1'b1;
      sink_stall_q <= 1'b1;
    end else if (!quiet_phase && $urandom_range(0, 19) == 0) begin
      sink_gap <= $urandom_range(0, 15);
      out_stall_i <= 1'b1;
      sink_stall_q <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      sink_stall_q <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (cycle_count > CYC_LIMIT) begin
      $display("** interval_partition_room_count_top: FAILED **");
      $finish;
    end
  end

  task automatic drain();
    while (pending_beats.size() > 0 || expected_counts.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    int sent;
    errors = 0; cycle_count = 0; quiet_phase = 0; hold_sink = 0; hold_cycles = 0;
    src_gap = 0; sink_gap = 0; sink_stall_q = 1'b1; set_dropped = 1'b0;
    rst_ni = 1'b0; in_valid_i = 1'b0; out_stall_i = 1'b1;
    in_data_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed sets: single, empty and reversed, touching ends, extremes, nesting.
    add_activity(32'd5, 32'd10, 1'b1);
    add_activity(32'd7, 32'd7, 1'b1);
    add_activity(32'd9, 32'd3, 1'b0);
    add_activity(32'hFFFF_FFFF, 32'd0, 1'b1);
    add_activity(32'd0, 32'd10, 1'b0);
    add_activity(32'd10, 32'd20, 1'b0);
    add_activity(32'd20, 32'd30, 1'b1);
    add_activity(32'd0, 32'hFFFF_FFFF, 1'b0);
    add_activity(32'd0, 32'hFFFF_FFFF, 1'b0);
    add_activity(32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1);
    add_activity(32'd1, 32'd100, 1'b0);
    add_activity(32'd2, 32'd50, 1'b0);
    add_activity(32'd3, 32'd4, 1'b0);
    add_activity(32'd100, 32'd101, 1'b1);
    add_activity(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    add_activity(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
    drain();

    // Full store, saturation and a dropped closing beat.
    for (int k = 0; k < 257; k++) add_activity(32'd0, 32'd1000 + k, k == 256);
    drain();
    for (int k = 0; k < 256; k++) add_activity(k, 32'd5000, 1'b0);
    add_activity(32'd1, 32'd2, 1'b1);
    drain();

    // Receiver holds off while the sender keeps offering.
    hold_sink = 1;
    for (int k = 0; k < 6; k++) add_random_set(3, 50);
    @(posedge clk_i);
    hold_sink = 0;
    drain();

    sent = 0;
    while (sent < 1200) begin
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
      add_random_set(n, ($urandom_range(0, 1) != 0) ? 20 : 100000);
      sent += n;
      if ($urandom_range(0, 30) == 0) drain();
      while (pending_beats.size() > 40) @(posedge clk_i);
      if (sent > 1050) quiet_phase = 1;
    end
    drain();
    repeat (3000) @(posedge clk_i);

    if (errors == 0 && expected_counts.size() == 0)
      $display("** interval_partition_room_count_top: PASSED **");
    else
      $display("** interval_partition_room_count_top: FAILED **");
    $finish;
  end

endmodule
